// ----- design/ttcs_pkg.sv -----
// Shared constants and widths for the triangle transform, cull and shade block.
package ttcs_pkg;

    // Viewport extent in pixels
    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 240;
    localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SCR_BITS      = $clog2(SCREEN_MAX + 1);

    // Projection numerator: 33-bit signed sum times the extent
    localparam int PNUM_W = 33 + SCR_BITS;

    // Divider: unsigned divisor and quotient widths, step count and compare width
    localparam int DEN_W     = 32;
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = QUO_W;
    localparam int CMP_W     = DEN_W + QUO_W;

    // Integer square root of the squared normal length
    localparam int SQ_IN_W  = 62;
    localparam int SQ_OUT_W = 31;
    localparam int SQ_STEPS = SQ_OUT_W;

    // Configuration register indexes (depth terms at 6 and 7 are dropped)
    localparam logic [2:0] REG_COS_Z   = 3'd0;
    localparam logic [2:0] REG_SIN_Z   = 3'd1;
    localparam logic [2:0] REG_COS_X   = 3'd2;
    localparam logic [2:0] REG_SIN_X   = 3'd3;
    localparam logic [2:0] REG_PROJ_XS = 3'd4;
    localparam logic [2:0] REG_PROJ_YS = 3'd5;

endpackage

// ----- design/ttcs_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module ttcs_isqrt
    import ttcs_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [SQ_IN_W-1:0]  rad,
    output logic [SQ_OUT_W-1:0] root
);

    logic [SQ_IN_W-1:0] rem_reg  [SQ_STEPS];
    logic [SQ_IN_W-1:0] root_reg [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
        localparam logic [SQ_IN_W:0] BIT = (SQ_IN_W + 1)'(1) << (2 * (SQ_STEPS - 1 - s));
        logic [SQ_IN_W-1:0] rem_in;
        logic [SQ_IN_W-1:0] r_in;
        logic [SQ_IN_W:0]   trial;
        logic               take;

        if (s == 0) begin : g_first
            assign rem_in = rad;
            assign r_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign r_in   = root_reg[s-1];
        end

        assign trial = (SQ_IN_W + 1)'(r_in) + BIT;
        assign take  = (SQ_IN_W + 1)'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= take ? SQ_IN_W'((SQ_IN_W + 1)'(rem_in) - trial) : rem_in;
                root_reg[s] <= take ? SQ_IN_W'((SQ_IN_W + 1)'(r_in >> 1) + BIT) : (r_in >> 1);
            end
        end
    end

    assign root = root_reg[SQ_STEPS-1][SQ_OUT_W-1:0];

endmodule

// ----- design/ttcs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ttcs_div
    import ttcs_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [PNUM_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo,
    output logic              ovf
);

    logic [CMP_W-1:0] rem_reg [DIV_STEPS];
    logic [DEN_W-1:0] den_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];
    logic             ovf_reg [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [CMP_W-1:0] rem_in;
        logic [CMP_W-1:0] dsh;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic             ovf_in;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = CMP_W'(num);
            assign den_in = den;
            assign quo_in = '0;
            // quotient would not fit in QUO_W bits
            assign ovf_in = CMP_W'(num) >= (CMP_W'(den) << QUO_W);
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign ovf_in = ovf_reg[s-1];
        end

        assign dsh  = CMP_W'(den_in) << (QUO_W - 1 - s);
        assign take = rem_in >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= take ? (rem_in - dsh) : rem_in;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_in | (QUO_W'(take) << (QUO_W - 1 - s));
                ovf_reg[s] <= ovf_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];
    assign ovf = ovf_reg[DIV_STEPS-1];

endmodule

// ----- design/triangle_transform_cull_shade.sv -----
// Triangle front end: rotate, back-face cull, flat shade and project to screen.
//
//  channel  | ports                        | item contents
//  ---------+------------------------------+---------------------------------------------
//  input    | s_tvalid s_tready s_tdata    | vertices A, B, C (x, y, z) signed Q8.8
//  result   | m_tvalid m_tready m_tdata    | screen x, y of A, B, C and 8-bit shade
//  config   | cfg_we cfg_idx cfg_wdata     | rotation and projection factors, Q4.12
//
// One triangle enters every cycle unless the output stalls; the 31-step square root
// is followed by the 17-step divider. Culled triangles leave a bubble.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults. A stall on m_tready freezes every stage and drops s_tready.
module triangle_transform_cull_shade
    import ttcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (16 bits each, from bit 0)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sx_a, sy_a, sx_b, sy_b, sx_c, sy_c (16 bits each), shade (8 bits), from bit 0
    output logic [103:0] m_tdata
);

    localparam int LAT      = 7 + SQ_STEPS + DIV_STEPS + 1;
    localparam int CULL_IDX = 4;

    typedef struct packed {
        logic [PNUM_W-1:0] num;
        logic [DEN_W-1:0]  den;
        logic              neg;
    } proj_t;

    typedef struct packed {
        proj_t [5:0] prj;
        logic [37:0] mz255;
        logic        nz_neg;
    } sq_dly_t;

    typedef struct packed {
        logic [5:0] neg;
        logic       nz_neg;
    } div_dly_t;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)
            return 16'sh7fff;
        if (v < -34'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // floor((s + 2048) / 4096), saturated
    function automatic logic signed [15:0] rnd_sat(input logic signed [32:0] s);
        logic signed [33:0] t;
        t = (34'(s) + 34'sd2048) >>> 12;
        return sat16(t);
    endfunction

    // ---------------- configuration ----------------
    logic signed [15:0] cos_z_reg, sin_z_reg, cos_x_reg, sin_x_reg;
    logic signed [15:0] pxs_reg, pys_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_z_reg <= 16'sd4096;
            sin_z_reg <= 16'sd0;
            cos_x_reg <= 16'sd4096;
            sin_x_reg <= 16'sd0;
            pxs_reg   <= 16'sd3840;
            pys_reg   <= 16'sd4096;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_COS_Z:   cos_z_reg <= cfg_wdata;
                REG_SIN_Z:   sin_z_reg <= cfg_wdata;
                REG_COS_X:   cos_x_reg <= cfg_wdata;
                REG_SIN_X:   sin_x_reg <= cfg_wdata;
                REG_PROJ_XS: pxs_reg   <= cfg_wdata;
                REG_PROJ_YS: pys_reg   <= cfg_wdata;
                default: ;  // depth terms have no effect on the result
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;
    logic           vis4;

    assign en       = ~vld_reg[LAT-1] | m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    // valid bits shift with the data; a culled triangle drops out at stage 5
    always_comb begin
        vld_next           = {vld_reg[LAT-2:0], s_tvalid};
        vld_next[CULL_IDX] = vld_reg[CULL_IDX-1] & vis4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 1: rotate about Z ----------------
    logic signed [15:0] x1_reg [3], y1_reg [3], z1_reg [3];
    logic signed [15:0] x1_next [3], y1_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [15:0] x, y;
            logic signed [31:0] pa, pb, pc, pd;
            x = s_tdata[48*i +: 16];
            y = s_tdata[48*i+16 +: 16];
            pa = x * cos_z_reg;
            pb = y * sin_z_reg;
            pc = x * sin_z_reg;
            pd = y * cos_z_reg;
            x1_next[i] = rnd_sat(33'(pa) - 33'(pb));
            y1_next[i] = rnd_sat(33'(pc) + 33'(pd));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                x1_reg[i] <= x1_next[i];
                y1_reg[i] <= y1_next[i];
                z1_reg[i] <= s_tdata[48*i+32 +: 16];
            end
        end
    end

    // ---------------- stage 2: rotate about X, push along z ----------------
    logic signed [15:0] vx2_reg [3], vy2_reg [3], vz2_reg [3];
    logic signed [15:0] vy2_next [3], vz2_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [31:0] pa, pb, pc, pd;
            logic signed [15:0] z2;
            pa = y1_reg[i] * cos_x_reg;
            pb = z1_reg[i] * sin_x_reg;
            pc = y1_reg[i] * sin_x_reg;
            pd = z1_reg[i] * cos_x_reg;
            vy2_next[i] = rnd_sat(33'(pa) - 33'(pb));
            z2          = rnd_sat(33'(pc) + 33'(pd));
            vz2_next[i] = sat16(34'(z2) + 34'sd768);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                vx2_reg[i] <= x1_reg[i];
                vy2_reg[i] <= vy2_next[i];
                vz2_reg[i] <= vz2_next[i];
            end
        end
    end

    // ---------------- stage 3: edges, cross product, x*p ----------------
    logic signed [34:0] nx3_reg, ny3_reg, nz3_reg;
    logic signed [34:0] nx3_next, ny3_next, nz3_next;
    logic signed [15:0] vx3_reg, vy3_reg, vz3_reg [3];
    logic signed [31:0] xp3_reg [3], yp3_reg [3];

    always_comb begin
        logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
        e1x = 17'(vx2_reg[1]) - 17'(vx2_reg[0]);
        e1y = 17'(vy2_reg[1]) - 17'(vy2_reg[0]);
        e1z = 17'(vz2_reg[1]) - 17'(vz2_reg[0]);
        e2x = 17'(vx2_reg[2]) - 17'(vx2_reg[0]);
        e2y = 17'(vy2_reg[2]) - 17'(vy2_reg[0]);
        e2z = 17'(vz2_reg[2]) - 17'(vz2_reg[0]);
        nx3_next = 35'(e1y * e2z) - 35'(e1z * e2y);
        ny3_next = 35'(e1z * e2x) - 35'(e1x * e2z);
        nz3_next = 35'(e1x * e2y) - 35'(e1y * e2x);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx3_reg <= nx3_next;
            ny3_reg <= ny3_next;
            nz3_reg <= nz3_next;
            vx3_reg <= vx2_reg[0];
            vy3_reg <= vy2_reg[0];
            for (int i = 0; i < 3; i++) begin
                vz3_reg[i] <= vz2_reg[i];
                xp3_reg[i] <= vx2_reg[i] * pxs_reg;
                yp3_reg[i] <= vy2_reg[i] * pys_reg;
            end
        end
    end

    // ---------------- stage 4: dot with A, magnitudes, projection setup ----------------
    logic signed [50:0] d0, d1, d2;
    logic signed [52:0] dot;
    logic               dot_neg4_reg, nzero4_reg, nz_neg4_reg;
    logic [34:0]        mx4_reg, my4_reg, mz4_reg;
    proj_t              prj4_reg [6];
    proj_t              prj4_next [6];

    assign d0  = nx3_reg * vx3_reg;
    assign d1  = ny3_reg * vy3_reg;
    assign d2  = nz3_reg * vz3_reg[0];
    assign dot = 53'(d0) + 53'(d1) + 53'(d2);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [15:0]       zz;
            logic [15:0]              zm;
            logic signed [32:0]       zt, px, py;
            logic signed [PNUM_W-1:0] nwx, nwy;
            logic [DEN_W-1:0]         dd;
            zz = vz3_reg[i];
            zm = zz[15] ? 16'(-zz) : 16'(zz);
            // depth zero: fixed offset 2^20 over 2^21 in place of the divide
            zt = (zz == 16'sd0) ? 33'sd1048576 : (33'(zz) <<< 12);
            dd = (zz == 16'sd0) ? DEN_W'(1 << 21) : (DEN_W'(zm) << 13);
            px = 33'(xp3_reg[i]) + zt;
            py = 33'(yp3_reg[i]) + zt;
            nwx = PNUM_W'(px) * PNUM_W'(SCREEN_WIDTH);
            nwy = PNUM_W'(py) * PNUM_W'(SCREEN_HEIGHT);
            prj4_next[2*i].num   = nwx[PNUM_W-1] ? PNUM_W'(-nwx) : PNUM_W'(nwx);
            prj4_next[2*i].den   = dd;
            prj4_next[2*i].neg   = nwx[PNUM_W-1] ^ zz[15];
            prj4_next[2*i+1].num = nwy[PNUM_W-1] ? PNUM_W'(-nwy) : PNUM_W'(nwy);
            prj4_next[2*i+1].den = dd;
            prj4_next[2*i+1].neg = nwy[PNUM_W-1] ^ zz[15];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_neg4_reg <= dot[52];
            nzero4_reg   <= (nx3_reg != '0) || (ny3_reg != '0) || (nz3_reg != '0);
            nz_neg4_reg  <= nz3_reg[34];
            mx4_reg      <= nx3_reg[34] ? 35'(-nx3_reg) : 35'(nx3_reg);
            my4_reg      <= ny3_reg[34] ? 35'(-ny3_reg) : 35'(ny3_reg);
            mz4_reg      <= nz3_reg[34] ? 35'(-nz3_reg) : 35'(nz3_reg);
            prj4_reg     <= prj4_next;
        end
    end

    // ---------------- stage 5: cull, common normalizing shift ----------------
    logic [34:0] morv;
    logic [2:0]  ksh;
    logic [29:0] mx5_reg, my5_reg, mz5_reg;
    logic        nz_neg5_reg;
    proj_t       prj5_reg [6];

    assign vis4 = dot_neg4_reg & nzero4_reg;
    assign morv = mx4_reg | my4_reg | mz4_reg;

    // least shift that brings every magnitude below 2^30
    always_comb begin
        ksh = 3'd0;
        for (int j = 0; j < 5; j++) begin
            if (morv[30+j])
                ksh = 3'(j + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx5_reg     <= 30'(mx4_reg >> ksh);
            my5_reg     <= 30'(my4_reg >> ksh);
            mz5_reg     <= 30'(mz4_reg >> ksh);
            nz_neg5_reg <= nz_neg4_reg;
            prj5_reg    <= prj4_reg;
        end
    end

    // ---------------- stage 6: squares ----------------
    logic [59:0] sqx6_reg, sqy6_reg, sqz6_reg;
    logic [29:0] mz6_reg;
    logic        nz_neg6_reg;
    proj_t       prj6_reg [6];

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx6_reg    <= mx5_reg * mx5_reg;
            sqy6_reg    <= my5_reg * my5_reg;
            sqz6_reg    <= mz5_reg * mz5_reg;
            mz6_reg     <= mz5_reg;
            nz_neg6_reg <= nz_neg5_reg;
            prj6_reg    <= prj5_reg;
        end
    end

    // ---------------- stage 7: squared length, 255*|nz| ----------------
    logic [SQ_IN_W-1:0] l2_7_reg;
    sq_dly_t            sq_in7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            l2_7_reg          <= SQ_IN_W'(sqx6_reg) + SQ_IN_W'(sqy6_reg) + SQ_IN_W'(sqz6_reg);
            sq_in7_reg.mz255  <= 38'(mz6_reg) * 38'd255;
            sq_in7_reg.nz_neg <= nz_neg6_reg;
            for (int i = 0; i < 6; i++)
                sq_in7_reg.prj[i] <= prj6_reg[i];
        end
    end

    // ---------------- square root, payload delayed alongside ----------------
    logic [SQ_OUT_W-1:0] len;
    sq_dly_t             sqd_reg [SQ_STEPS];

    ttcs_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (l2_7_reg),
        .root (len)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sqd_reg[0] <= sq_in7_reg;
            for (int i = 1; i < SQ_STEPS; i++)
                sqd_reg[i] <= sqd_reg[i-1];
        end
    end

    // ---------------- dividers: six projections and the shade ----------------
    logic [QUO_W-1:0] dv_quo [7];
    logic             dv_ovf [7];
    div_dly_t         dvd_reg [DIV_STEPS];
    div_dly_t         dvd_in;

    for (genvar g = 0; g < 6; g++) begin : g_proj
        ttcs_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (sqd_reg[SQ_STEPS-1].prj[g].num),
            .den  (sqd_reg[SQ_STEPS-1].prj[g].den),
            .quo  (dv_quo[g]),
            .ovf  (dv_ovf[g])
        );
        assign dvd_in.neg[g] = sqd_reg[SQ_STEPS-1].prj[g].neg;
    end

    ttcs_div u_div_shade (
        .aclk (aclk),
        .en   (en),
        .num  (PNUM_W'(sqd_reg[SQ_STEPS-1].mz255)),
        .den  (DEN_W'(len)),
        .quo  (dv_quo[6]),
        .ovf  (dv_ovf[6])
    );

    assign dvd_in.nz_neg = sqd_reg[SQ_STEPS-1].nz_neg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0] <= dvd_in;
            for (int i = 1; i < DIV_STEPS; i++)
                dvd_reg[i] <= dvd_reg[i-1];
        end
    end

    // ---------------- output: sign, saturate, pack ----------------
    logic [103:0] m_tdata_reg, m_tdata_next;

    always_comb begin
        for (int g = 0; g < 6; g++) begin
            logic [QUO_W-1:0] q;
            q = dv_quo[g];
            if (dvd_reg[DIV_STEPS-1].neg[g]) begin
                if (dv_ovf[g] || q > QUO_W'(32768))
                    m_tdata_next[16*g +: 16] = 16'h8000;
                else
                    m_tdata_next[16*g +: 16] = 16'(-q);
            end else begin
                if (dv_ovf[g] || q > QUO_W'(32767))
                    m_tdata_next[16*g +: 16] = 16'h7fff;
                else
                    m_tdata_next[16*g +: 16] = q[15:0];
            end
        end
        // light along -z: only normals facing it get a gray level
        if (!dvd_reg[DIV_STEPS-1].nz_neg)
            m_tdata_next[103:96] = 8'd0;
        else if (dv_ovf[6] || dv_quo[6] > QUO_W'(255))
            m_tdata_next[103:96] = 8'd255;
        else
            m_tdata_next[103:96] = dv_quo[6][7:0];
    end

    always_ff @(posedge aclk) begin
        if (en)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tdata = m_tdata_reg;

    // ---------------- checks ----------------
    a_cull_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[CULL_IDX-1] && !vis4) |=> !vld_reg[CULL_IDX])
        else $error("culled triangle kept its valid bit");

    a_shade_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT-2] |-> !dv_ovf[6])
        else $error("shade quotient overflow on a visible triangle");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(vld_reg) && $stable(m_tdata_reg)))
        else $error("pipeline moved during a stall");

endmodule
